>>> rtl/core/wfdc_pkg.sv
// ----------------------------------------------------------------------------
// wfdc_pkg
// Shared types and constants for the weigh-feed-dispense controller.
// ----------------------------------------------------------------------------
package wfdc_pkg;

  localparam int CmdValueW = 19;
  localparam int WeightW   = 20;
  localparam int HourW     = 5;
  localparam int MinuteW   = 6;
  localparam int TicksW    = 16;
  localparam int ReportW   = 19;
  localparam int DispW     = 20;
  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 2;

  // switch commands mean "on" for a value above 5
  localparam logic [CmdValueW-1:0] SWITCH_ON_ABOVE = 19'd5;

  localparam logic [TicksW-1:0] AUTO_TIMEOUT_RST = 16'd1000;
  localparam logic [TicksW-1:0] RUN_TIMEOUT_RST  = 16'd1500;
  localparam logic [HourW-1:0]  FEED_HOUR_FIRST_RST  = 5'd6;
  localparam logic [HourW-1:0]  FEED_HOUR_SECOND_RST = 5'd17;
  localparam logic [HourW-1:0]  HOUR_NONE = 5'd31;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_AUTO   = 2'd1,
    CMD_GRAM   = 2'd2,
    CMD_MANUAL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_GRAM   = 2'd2,
    MODE_MANUAL = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_TARGET    = 3'd1,
    CAUSE_TIMEOUT   = 3'd2,
    CAUSE_CANCELLED = 3'd3,
    CAUSE_SWITCHED  = 3'd4
  } cause_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_AUTO_TIMEOUT = 2'd0,
    REG_RUN_TIMEOUT  = 2'd1,
    REG_HOUR_FIRST   = 2'd2,
    REG_HOUR_SECOND  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [TicksW-1:0] auto_timeout;
    logic [TicksW-1:0] run_timeout;
    logic [HourW-1:0]  hour_first;
    logic [HourW-1:0]  hour_second;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [CmdValueW-1:0]      cmd_value;
    logic                      sample_ready;
    logic signed [WeightW-1:0] weight_sample;
    logic [HourW-1:0]          clock_hour;
    logic [MinuteW-1:0]        clock_minute;
  } item_t;

  typedef struct packed {
    logic                   motor_on;
    mode_t                  mode;
    logic [ReportW-1:0]     weight_report;
    cause_t                 cause;
    logic [DispW-1:0]       dispensed;
  } result_t;

endpackage

>>> rtl/core/wfdc_ctrl.sv
// ----------------------------------------------------------------------------
// wfdc_ctrl
// Feeder control state and the per-period update: command handling, mode
// logic, run timeouts and dispensed-weight reporting.
// ----------------------------------------------------------------------------
module wfdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  wfdc_pkg::item_t  item,
  input  wfdc_pkg::cfg_t   cfg,
  output wfdc_pkg::result_t res
);
  import wfdc_pkg::*;

  // state registers
  mode_t                     mode;
  logic                      running;
  logic [TicksW-1:0]         ticks;
  logic signed [WeightW-1:0] start_w;
  logic [CmdValueW-1:0]      target;
  logic signed [WeightW-1:0] held;
  logic [HourW-1:0]          last_hour;

  mode_t                     mode_next;
  logic                      running_next;
  logic [TicksW-1:0]         ticks_next;
  logic signed [WeightW-1:0] start_w_next;
  logic [CmdValueW-1:0]      target_next;
  logic signed [WeightW-1:0] held_next;
  logic [HourW-1:0]          last_hour_next;

  cause_t                    cause;
  logic [DispW-1:0]          disp;
  logic                      started;
  logic                      switch_on;
  logic                      slot;
  logic                      tout;
  logic                      reached;
  logic signed [WeightW:0]   diff;

  function automatic logic [DispW-1:0] disp_of(logic signed [WeightW-1:0] s,
                                               logic signed [WeightW-1:0] h);
    logic signed [WeightW:0] d;
    d = {s[WeightW-1], s} - {h[WeightW-1], h};
    return (!d[WeightW] && (d != '0)) ? d[DispW-1:0] : '0;
  endfunction

  always_comb begin
    mode_next      = mode;
    running_next   = running;
    ticks_next     = ticks;
    start_w_next   = start_w;
    target_next    = target;
    last_hour_next = last_hour;
    cause          = CAUSE_NONE;
    disp           = '0;
    started        = 1'b0;
    tout           = 1'b0;
    slot           = 1'b0;
    diff           = '0;
    reached        = 1'b0;
    held_next      = item.sample_ready ? item.weight_sample : held;
    switch_on      = item.cmd_value > SWITCH_ON_ABOVE;

    unique case (cmd_t'(item.cmd))
      CMD_AUTO: begin
        if (switch_on) begin
          mode_next = MODE_AUTO;
        end else begin
          mode_next = MODE_IDLE;
          if (running_next) begin
            running_next = 1'b0;
            ticks_next   = '0;
            cause        = CAUSE_CANCELLED;
            disp         = disp_of(start_w_next, held_next);
          end
        end
      end
      CMD_GRAM: begin
        target_next = item.cmd_value;
        if (item.cmd_value != '0) begin
          mode_next = MODE_GRAM;
        end else begin
          mode_next = MODE_IDLE;
          if (running_next) begin
            running_next = 1'b0;
            ticks_next   = '0;
            cause        = CAUSE_CANCELLED;
            disp         = disp_of(start_w_next, held_next);
          end
        end
      end
      CMD_MANUAL: begin
        if (switch_on) begin
          start_w_next = held_next;
          running_next = 1'b1;
          ticks_next   = '0;
          started      = 1'b1;
          mode_next    = MODE_MANUAL;
        end else begin
          mode_next = MODE_IDLE;
          if (running_next) begin
            running_next = 1'b0;
            ticks_next   = '0;
            cause        = CAUSE_SWITCHED;
            disp         = disp_of(start_w_next, held_next);
          end
        end
      end
      default: ;
    endcase

    unique case (mode_next)
      MODE_AUTO: begin
        if (!running_next) begin
          slot = (item.clock_minute == '0) &&
                 ((item.clock_hour == cfg.hour_first &&
                   last_hour_next != cfg.hour_first) ||
                  (item.clock_hour == cfg.hour_second &&
                   last_hour_next != cfg.hour_second));
          if (slot) begin
            last_hour_next = item.clock_hour;
            start_w_next   = held_next;
            running_next   = 1'b1;
            ticks_next     = '0;
          end
        end else if (!started) begin
          if (ticks_next >= cfg.auto_timeout) begin
            running_next = 1'b0;
            ticks_next   = '0;
            cause        = CAUSE_TIMEOUT;
            disp         = disp_of(start_w_next, held_next);
            mode_next    = MODE_IDLE;
          end else begin
            ticks_next = ticks_next + 1'b1;
          end
        end
      end
      MODE_GRAM: begin
        if (!running_next && target_next != '0) begin
          start_w_next = held_next;
          running_next = 1'b1;
          ticks_next   = '0;
          started      = 1'b1;
        end
        if (running_next) begin
          if (!started) begin
            if (ticks_next >= cfg.run_timeout) tout = 1'b1;
            else ticks_next = ticks_next + 1'b1;
          end
          // weight drop since start versus target
          diff    = {start_w_next[WeightW-1], start_w_next}
                  - {held_next[WeightW-1], held_next};
          reached = $signed({diff[WeightW], diff}) >=
                    $signed({3'b000, target_next});
          if (tout || reached) begin
            running_next = 1'b0;
            ticks_next   = '0;
            cause        = tout ? CAUSE_TIMEOUT : CAUSE_TARGET;
            disp         = disp_of(start_w_next, held_next);
            mode_next    = MODE_IDLE;
            target_next  = '0;
          end
        end
      end
      MODE_MANUAL: begin
        if (running_next && !started) begin
          if (ticks_next >= cfg.run_timeout) begin
            running_next = 1'b0;
            ticks_next   = '0;
            cause        = CAUSE_TIMEOUT;
            disp         = disp_of(start_w_next, held_next);
          end else begin
            ticks_next = ticks_next + 1'b1;
          end
        end
      end
      MODE_IDLE: begin
        if (running_next) begin
          running_next = 1'b0;
          ticks_next   = '0;
          cause        = CAUSE_SWITCHED;
          disp         = disp_of(start_w_next, held_next);
        end
      end
      default: ;
    endcase
  end

  assign res.motor_on      = running_next;
  assign res.mode          = mode_next;
  assign res.weight_report = (!held_next[WeightW-1] && held_next != '0) ?
                             held_next[ReportW-1:0] : '0;
  assign res.cause         = cause;
  assign res.dispensed     = disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      running   <= 1'b0;
      ticks     <= '0;
      start_w   <= '0;
      target    <= '0;
      held      <= '0;
      last_hour <= HOUR_NONE;
    end else if (en) begin
      mode      <= mode_next;
      running   <= running_next;
      ticks     <= ticks_next;
      start_w   <= start_w_next;
      target    <= target_next;
      held      <= held_next;
      last_hour <= last_hour_next;
    end
  end

endmodule

>>> rtl/core/weigh_feed_dispense_controller.sv
// ----------------------------------------------------------------------------
// weigh_feed_dispense_controller
// Feeder motor controller with a weighing hopper: one request per control
// period, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one control period: an
//   optional command, a load-cell sample with its ready flag and the wall
//   clock hour and minute. Output channel (out_valid / out_stall) returns
//   motor state, mode, clamped held weight, stop cause and grams dispensed.
//   A request taken into the input register passes the control update into
//   the result register, and out_valid is high once the result is held
//   there. Throughput is one request per cycle while the receiver does not
//   stall, set by the control update whose state feeds the next request
//   directly.
//   When the receiver stalls, the result register holds and the input
//   register stays full; in_stall rises only when both are occupied.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the
//   user must make them while no request is in flight (not enforced here).
//   Reset (rst, synchronous) empties both registers, puts the feeder in idle
//   with the motor off, clears the held weight and loads the default
//   timeouts and feeding hours.
// ----------------------------------------------------------------------------
module weigh_feed_dispense_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wfdc_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [wfdc_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [wfdc_pkg::CmdValueW-1:0]      cmd_value,
  input  logic                                sample_ready,
  input  logic signed [wfdc_pkg::WeightW-1:0] weight_sample,
  input  logic [wfdc_pkg::HourW-1:0]          clock_hour,
  input  logic [wfdc_pkg::MinuteW-1:0]        clock_minute,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                motor_on,
  output logic [1:0]                          feed_mode,
  output logic [wfdc_pkg::ReportW-1:0]        weight_report,
  output logic [2:0]                          stop_cause,
  output logic [wfdc_pkg::DispW-1:0]          dispensed
);
  import wfdc_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  item_t   s1_item;
  logic    out_ready;
  logic    advance;
  result_t res_next;
  result_t res;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_timeout <= AUTO_TIMEOUT_RST;
      cfg.run_timeout  <= RUN_TIMEOUT_RST;
      cfg.hour_first   <= FEED_HOUR_FIRST_RST;
      cfg.hour_second  <= FEED_HOUR_SECOND_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_AUTO_TIMEOUT: cfg.auto_timeout <= cfg_data;
        REG_RUN_TIMEOUT:  cfg.run_timeout  <= cfg_data;
        REG_HOUR_FIRST:   cfg.hour_first   <= cfg_data[HourW-1:0];
        REG_HOUR_SECOND:  cfg.hour_second  <= cfg_data[HourW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.cmd           <= cmd;
      s1_item.cmd_value     <= cmd_value;
      s1_item.sample_ready  <= sample_ready;
      s1_item.weight_sample <= weight_sample;
      s1_item.clock_hour    <= clock_hour;
      s1_item.clock_minute  <= clock_minute;
    end
  end

  wfdc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign motor_on      = res.motor_on;
  assign feed_mode     = res.mode;
  assign weight_report = res.weight_report;
  assign stop_cause    = res.cause;
  assign dispensed     = res.dispensed;

endmodule

>>> rtl/core/wfdc_check.sv
// ----------------------------------------------------------------------------
// wfdc_check
// Port-level checks for the weigh-feed-dispense controller, bound to the top.
// ----------------------------------------------------------------------------
module wfdc_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                motor_on,
  input logic [1:0]                          feed_mode,
  input logic [2:0]                          stop_cause,
  input logic [wfdc_pkg::DispW-1:0]          dispensed
);
  import wfdc_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_on) &&
                              $stable(stop_cause) && $stable(dispensed))
    else $error("stalled result changed");

  // a stop leaves the motor off
  a_stop_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_cause != CAUSE_NONE |-> !motor_on)
    else $error("motor on in a stop period");

  // idle never drives the motor
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && feed_mode == MODE_IDLE |-> !motor_on)
    else $error("motor on in idle mode");

  // dispensed is reported only with a stop
  a_disp: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_cause == CAUSE_NONE |-> dispensed == '0)
    else $error("dispensed without a stop");

  // no request is refused while the result register is empty
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> !in_stall)
    else $error("stall with empty output");

endmodule

bind weigh_feed_dispense_controller wfdc_check u_wfdc_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .motor_on   (motor_on),
  .feed_mode  (feed_mode),
  .stop_cause (stop_cause),
  .dispensed  (dispensed)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the feeder controller: control periods go in on
// the request channel, and every result is checked against a cycle-free model
// of the motor, mode, held weight, stop cause and dispensed grams.
// ----------------------------------------------------------------------------
module testbench;
  import wfdc_pkg::*;

  typedef struct {
    item_t req;
    bit    drain_first;
  } period_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  item_t                in_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 motor_on;
  logic [1:0]           feed_mode;
  logic [ReportW-1:0]   weight_report;
  logic [2:0]           stop_cause;
  logic [DispW-1:0]     dispensed;

  period_t period_q[$];
  result_t due_reports[$];
  result_t want;
  int      mismatches = 0;
  int      items_queued = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  // feeder model state
  cfg_t         cfg_shadow = '{AUTO_TIMEOUT_RST, RUN_TIMEOUT_RST,
                               FEED_HOUR_FIRST_RST, FEED_HOUR_SECOND_RST};
  mode_t        fdr_mode = MODE_IDLE;
  bit           fdr_motor = 1'b0;
  int           fdr_ticks = 0;
  int           fdr_start = 0;
  int           fdr_target = 0;
  int           fdr_weight = 0;
  logic [4:0]   fdr_last_hour = HOUR_NONE;
  cause_t       fdr_cause;
  logic [19:0]  fdr_disp;

  weigh_feed_dispense_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (in_req.cmd),
    .cmd_value     (in_req.cmd_value),
    .sample_ready  (in_req.sample_ready),
    .weight_sample (in_req.weight_sample),
    .clock_hour    (in_req.clock_hour),
    .clock_minute  (in_req.clock_minute),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motor_on      (motor_on),
    .feed_mode     (feed_mode),
    .weight_report (weight_report),
    .stop_cause    (stop_cause),
    .dispensed     (dispensed)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void start_feed();
    fdr_start = fdr_weight;
    fdr_motor = 1'b1;
    fdr_ticks = 0;
  endfunction

  function automatic void stop_feed(cause_t why);
    int d;
    d = fdr_start - fdr_weight;
    fdr_motor = 1'b0;
    fdr_ticks = 0;
    fdr_cause = why;
    fdr_disp = (d > 0) ? d[19:0] : '0;
  endfunction

  // count one more run period unless the limit is already reached
  function automatic bit run_expired(int limit);
    if (fdr_ticks >= limit) return 1'b1;
    fdr_ticks = (fdr_ticks + 1) & 16'hFFFF;
    return 1'b0;
  endfunction

  function automatic result_t feeder_step(item_t req);
    result_t res;
    bit      started;
    bit      slot;
    bit      tout;
    bit      reached;
    started = 1'b0;
    fdr_cause = CAUSE_NONE;
    fdr_disp = '0;
    if (req.sample_ready) fdr_weight = int'(req.weight_sample);

    case (cmd_t'(req.cmd))
      CMD_AUTO: begin
        if (req.cmd_value > SWITCH_ON_ABOVE) begin
          fdr_mode = MODE_AUTO;
        end else begin
          fdr_mode = MODE_IDLE;
          if (fdr_motor) stop_feed(CAUSE_CANCELLED);
        end
      end
      CMD_GRAM: begin
        fdr_target = int'(req.cmd_value);
        if (fdr_target > 0) begin
          fdr_mode = MODE_GRAM;
        end else begin
          fdr_mode = MODE_IDLE;
          if (fdr_motor) stop_feed(CAUSE_CANCELLED);
        end
      end
      CMD_MANUAL: begin
        if (req.cmd_value > SWITCH_ON_ABOVE) begin
          start_feed();
          started = 1'b1;
          fdr_mode = MODE_MANUAL;
        end else begin
          fdr_mode = MODE_IDLE;
          if (fdr_motor) stop_feed(CAUSE_SWITCHED);
        end
      end
      default: ;
    endcase

    case (fdr_mode)
      MODE_AUTO: begin
        if (!fdr_motor) begin
          slot = (req.clock_minute == 0) &&
                 ((req.clock_hour == cfg_shadow.hour_first &&
                   fdr_last_hour != cfg_shadow.hour_first) ||
                  (req.clock_hour == cfg_shadow.hour_second &&
                   fdr_last_hour != cfg_shadow.hour_second));
          if (slot) begin
            fdr_last_hour = req.clock_hour;
            start_feed();
          end
        end else if (!started) begin
          if (run_expired(int'(cfg_shadow.auto_timeout))) begin
            stop_feed(CAUSE_TIMEOUT);
            fdr_mode = MODE_IDLE;
          end
        end
      end
      MODE_GRAM: begin
        if (!fdr_motor && fdr_target > 0) begin
          start_feed();
          started = 1'b1;
        end
        if (fdr_motor) begin
          tout = 1'b0;
          if (!started) tout = run_expired(int'(cfg_shadow.run_timeout));
          reached = (fdr_start - fdr_weight) >= fdr_target;
          if (tout || reached) begin
            stop_feed(tout ? CAUSE_TIMEOUT : CAUSE_TARGET);
            fdr_mode = MODE_IDLE;
            fdr_target = 0;
          end
        end
      end
      MODE_MANUAL: begin
        if (fdr_motor && !started) begin
          if (run_expired(int'(cfg_shadow.run_timeout))) stop_feed(CAUSE_TIMEOUT);
        end
      end
      default: begin
        if (fdr_motor) stop_feed(CAUSE_SWITCHED);
      end
    endcase

    res.motor_on = fdr_motor;
    res.mode = fdr_mode;
    res.weight_report = (fdr_weight > 0) ? fdr_weight[18:0] : '0;
    res.cause = fdr_cause;
    res.dispensed = fdr_disp;
    return res;
  endfunction

  // ------------------------------------------------------- driver, monitor

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_reports.push_back(feeder_step(in_req));
      if (!in_valid || !in_stall) begin
        // hold a drain-marked request back until every report is in
        if (period_q.size() > 0 &&
            !(period_q[0].drain_first && due_reports.size() > 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_req <= period_q[0].req;
          in_valid <= 1'b1;
          void'(period_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result: motor_on %0d feed_mode %0d", motor_on, feed_mode);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (motor_on !== want.motor_on) begin
          $error("motor_on: expected %0d, got %0d", want.motor_on, motor_on);
          mismatches++;
        end
        if (feed_mode !== want.mode) begin
          $error("feed_mode: expected %0d, got %0d", want.mode, feed_mode);
          mismatches++;
        end
        if (weight_report !== want.weight_report) begin
          $error("weight_report: expected %0d, got %0d", want.weight_report, weight_report);
          mismatches++;
        end
        if (stop_cause !== want.cause) begin
          $error("stop_cause: expected %0d, got %0d", want.cause, stop_cause);
          mismatches++;
        end
        if (dispensed !== want.dispensed) begin
          $error("dispensed: expected %0d, got %0d", want.dispensed, dispensed);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ------------------------------------------------------------- stimulus

  function automatic int rand_weight();
    return int'($urandom_range(1000000)) - 500000;
  endfunction

  // switch values around the on threshold, or any target
  function automatic logic [18:0] pick_value();
    case ($urandom_range(3))
      0: return 19'($urandom_range(5));
      1: return SWITCH_ON_ABOVE + 19'd1;
      default: return 19'($urandom_range(500000));
    endcase
  endfunction

  task automatic queue_req(cmd_t c, logic [18:0] v, bit rdy, int w, int hr, int mn,
                           bit drain = 1'b0);
    period_t p;
    p.req.cmd = c;
    p.req.cmd_value = v;
    p.req.sample_ready = rdy;
    p.req.weight_sample = w[19:0];
    p.req.clock_hour = hr[4:0];
    p.req.clock_minute = mn[5:0];
    p.drain_first = drain || ($urandom_range(149) == 0);
    period_q.push_back(p);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (period_q.size() != 0 || in_valid || due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AUTO_TIMEOUT: cfg_shadow.auto_timeout = val;
      REG_RUN_TIMEOUT:  cfg_shadow.run_timeout = val;
      REG_HOUR_FIRST:   cfg_shadow.hour_first = val[4:0];
      default:          cfg_shadow.hour_second = val[4:0];
    endcase
  endtask

  task automatic configure(logic [15:0] auto_to, logic [15:0] run_to,
                           logic [4:0] hour_a, logic [4:0] hour_b);
    wait_idle();
    write_reg(REG_AUTO_TIMEOUT, auto_to);
    write_reg(REG_RUN_TIMEOUT, run_to);
    write_reg(REG_HOUR_FIRST, 16'(hour_a));
    write_reg(REG_HOUR_SECOND, 16'(hour_b));
  endtask

  // one feed session: opening command, a weight walk, maybe a stop command;
  // the idle kind stands for unstructured traffic
  task automatic queue_session(mode_t kind);
    int          len;
    int          lim;
    int          hr;
    int          mn;
    int          w;
    int          drop;
    int          chance;
    bit          rdy;
    cmd_t        c;
    logic [18:0] v;
    w = ($urandom_range(3) == 0) ? rand_weight() : int'($urandom_range(50000));
    hr = $urandom_range(23);
    lim = int'(cfg_shadow.run_timeout);
    drop = 200;
    chance = 6;
    case (kind)
      MODE_AUTO: begin
        lim = int'(cfg_shadow.auto_timeout);
        if ($urandom_range(6) == 0) hr = $urandom_range(31);
        else hr = $urandom_range(1) ? cfg_shadow.hour_first : cfg_shadow.hour_second;
        queue_req(CMD_AUTO, 19'($urandom_range(500000, 6)), 1'b1, w, hr, 0);
      end
      MODE_GRAM: begin
        v = ($urandom_range(9) == 0) ? 19'($urandom_range(500000, 1))
                                     : 19'($urandom_range(3000, 1));
        drop = int'(v) / 4 + 2;
        queue_req(CMD_GRAM, v, 1'b1, w, hr, $urandom_range(59));
      end
      MODE_MANUAL: begin
        queue_req(CMD_MANUAL, 19'($urandom_range(500000, 6)), 1'b1, w, hr,
                  $urandom_range(59));
      end
      default: chance = 50;
    endcase
    if (lim > 30) lim = 30;
    len = $urandom_range(lim + 3, 1);
    for (int k = 0; k < len; k++) begin
      w = w - int'($urandom_range(drop));
      if (w < -500000) w = -500000;
      rdy = ($urandom_range(99) < 85);
      if (kind == MODE_IDLE) hr = $urandom_range(31);
      mn = (kind == MODE_AUTO && $urandom_range(3) == 0) ? 0 : $urandom_range(59);
      if ($urandom_range(99) < chance) begin
        c = cmd_t'($urandom_range(3));
        v = pick_value();
      end else begin
        c = CMD_NONE;
        v = 19'($urandom_range(500000));
      end
      queue_req(c, v, rdy, rdy ? w : rand_weight(), hr, mn);
    end
    if ($urandom_range(99) < 35) begin
      case (kind)
        MODE_AUTO:   queue_req(CMD_AUTO, 19'($urandom_range(5)), 1'b1, w, hr, 1);
        MODE_GRAM:   queue_req(CMD_GRAM, 19'd0, 1'b1, w, hr, 1);
        MODE_MANUAL: queue_req(CMD_MANUAL, 19'($urandom_range(5)), 1'b1, w, hr, 1);
        default: ;
      endcase
    end
  endtask

  task automatic load_traffic(int n_items);
    int goal;
    goal = items_queued + n_items;
    while (items_queued < goal) queue_session(mode_t'($urandom_range(3)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 62;

    configure(16'd3, 16'd4, 5'd6, 5'd17);
    queue_req(CMD_NONE, 19'd0, 1'b1, 500000, 0, 0);
    queue_req(CMD_NONE, 19'd0, 1'b1, -500000, 31, 0);
    // stale sample: the held weight must not move
    queue_req(CMD_NONE, 19'd500000, 1'b0, 4321, 23, 59);
    queue_req(CMD_AUTO, 19'd6, 1'b1, 10000, 6, 0);
    for (int k = 1; k <= 4; k++) queue_req(CMD_NONE, 19'd0, 1'b1, 10000 - 700 * k, 6, k);
    // same hour again: already fed, no start
    queue_req(CMD_AUTO, 19'd500000, 1'b1, 9000, 6, 0);
    queue_req(CMD_NONE, 19'd0, 1'b1, 9000, 17, 0);
    queue_req(CMD_AUTO, 19'd5, 1'b1, 8000, 17, 1);
    queue_req(CMD_GRAM, 19'd50, 1'b1, 2000, 8, 0, 1'b1);
    queue_req(CMD_NONE, 19'd0, 1'b1, 1980, 8, 1);
    queue_req(CMD_NONE, 19'd0, 1'b1, 1950, 8, 2);
    // rising weight: gram run times out with nothing dispensed
    queue_req(CMD_GRAM, 19'd500000, 1'b1, 3000, 9, 0);
    for (int k = 1; k <= 5; k++) queue_req(CMD_NONE, 19'd0, 1'b1, 3000 + k, 9, k);
    queue_req(CMD_GRAM, 19'd0, 1'b1, 3000, 9, 6);
    queue_req(CMD_MANUAL, 19'd6, 1'b1, 2500, 10, 0);
    queue_req(CMD_MANUAL, 19'd500000, 1'b1, 2400, 10, 1);
    queue_req(CMD_MANUAL, 19'd5, 1'b1, 2000, 10, 2);
    queue_req(CMD_MANUAL, 19'd100, 1'b1, 2000, 10, 3);
    queue_req(CMD_GRAM, 19'd0, 1'b1, 1900, 10, 4);

    configure(16'd1, 16'd1, 5'd0, 5'd23);
    load_traffic(250);
    configure(16'd65535, 16'd65535, 5'd23, 5'd0);
    load_traffic(100);

    send_idle_pct = 62;
    recv_idle_pct = 12;
    configure(16'($urandom_range(20, 2)), 16'($urandom_range(20, 2)),
              5'($urandom_range(23)), 5'($urandom_range(23)));
    load_traffic(200);
    configure(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
              5'($urandom_range(23)), 5'($urandom_range(23)));
    load_traffic(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
              5'($urandom_range(23)), 5'($urandom_range(23)));
    load_traffic(250);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run guard: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/wfdc_pkg.sv
rtl/core/wfdc_ctrl.sv
rtl/core/weigh_feed_dispense_controller.sv
rtl/core/wfdc_check.sv
sim/testbench.sv
